>>> src/tlpc_pkg.sv
// Shared widths for the triangle lattice point counter.
`default_nettype none
package tlpc_pkg;

  // Width of one vertex coordinate on the request port.
  localparam int COORD_W = 15;
  // Width of the point count on the result port.
  localparam int COUNT_W = 14;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage
`default_nettype wire

>>> src/triangle_lattice_point_count_unit.sv
// Top level of the triangle lattice point counter: point scanner, area pipeline and counter.
`default_nettype none
// Counts the integer grid points (i, j), 1 <= i, j <= GRID_MAX, that lie inside or on the
// border of one triangle whose vertices come in unsigned fixed point with FRAC_BITS fraction
// bits. One triangle is worked on at a time: after a request is taken, a scanner feeds one
// grid point per cycle into a four-stage area pipeline (coordinate differences, products,
// signed cross products, sign test), and the count is valid once the scan is done and the
// pipeline has drained. The result sits in an output register, so the next request is taken
// in the cycle after the count is loaded, even while that count still waits to be taken. A
// count is only loaded when the output register is empty or its count is taken in the same
// cycle. A point counts when the three signed sub-areas it forms with the edges never have
// both strictly positive and strictly negative members, which is exactly when their
// absolute values add up to the whole area.
module triangle_lattice_point_count_unit
  import tlpc_pkg::*;
#(
  parameter int GRID_MAX  = 99,
  parameter int FRAC_BITS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire coord_t in_ax,
  input  wire coord_t in_ay,
  input  wire coord_t in_bx,
  input  wire coord_t in_by,
  input  wire coord_t in_cx,
  input  wire coord_t in_cy,
  output logic        out_valid,
  input  wire logic   out_stall,
  output count_t      out_tree_count
);

  localparam int IW  = $clog2(GRID_MAX + 1);
  localparam int PW  = IW + FRAC_BITS;
  localparam int CW  = (PW > COORD_W) ? PW : COORD_W;
  localparam int DW  = CW + 1;
  localparam int PRW = 2 * DW;
  localparam int CRW = PRW + 1;

  localparam logic [IW-1:0] IDX_FIRST = IW'(1);
  localparam logic [IW-1:0] IDX_LAST  = IW'(GRID_MAX);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  coord_t        ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  count_t        cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  count_t        out_count_r, out_count_nxt;

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic                  issue;
  logic                  load_out;
  logic [PW-1:0]         px, py;
  logic signed [DW-1:0]  dax_r, day_r, dbx_r, dby_r, dcx_r, dcy_r;
  logic signed [PRW-1:0] p_ab_r, p_ba_r, p_bc_r, p_cb_r, p_ca_r, p_ac_r;
  logic signed [CRW-1:0] c1_r, c2_r, c3_r;
  logic                  hit_r;
  logic                  any_pos, any_neg;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_tree_count = out_count_r;

  assign issue    = (state_r == ST_SCAN);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign px = PW'(i_r) << FRAC_BITS;
  assign py = PW'(j_r) << FRAC_BITS;

  // Scan sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (v4_r && hit_r) begin
      cnt_nxt = cnt_r + COUNT_W'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          i_nxt     = IDX_FIRST;
          j_nxt     = IDX_FIRST;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (j_r == IDX_LAST) begin
          j_nxt = IDX_FIRST;
          if (i_r == IDX_LAST) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (!(v1_r || v2_r || v3_r || v4_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
    if (in_valid && !in_stall) begin
      ax_r <= in_ax;
      ay_r <= in_ay;
      bx_r <= in_bx;
      by_r <= in_by;
      cx_r <= in_cx;
      cy_r <= in_cy;
    end
  end

  // Stage 1: vertex minus grid point, all as signed differences.
  always_ff @(posedge clk) begin
    dax_r <= DW'(ax_r) - DW'(px);
    day_r <= DW'(ay_r) - DW'(py);
    dbx_r <= DW'(bx_r) - DW'(px);
    dby_r <= DW'(by_r) - DW'(py);
    dcx_r <= DW'(cx_r) - DW'(px);
    dcy_r <= DW'(cy_r) - DW'(py);
  end

  // Stage 2: the six products of the three cross products.
  always_ff @(posedge clk) begin
    p_ab_r <= PRW'(dax_r) * PRW'(dby_r);
    p_ba_r <= PRW'(dbx_r) * PRW'(day_r);
    p_bc_r <= PRW'(dbx_r) * PRW'(dcy_r);
    p_cb_r <= PRW'(dcx_r) * PRW'(dby_r);
    p_ca_r <= PRW'(dcx_r) * PRW'(day_r);
    p_ac_r <= PRW'(dax_r) * PRW'(dcy_r);
  end

  // Stage 3: signed doubled areas of the sub-triangles (P,A,B), (P,B,C) and (P,C,A).
  always_ff @(posedge clk) begin
    c1_r <= CRW'(p_ab_r) - CRW'(p_ba_r);
    c2_r <= CRW'(p_bc_r) - CRW'(p_cb_r);
    c3_r <= CRW'(p_ca_r) - CRW'(p_ac_r);
  end

  // Stage 4: the signed sub-areas add up to the signed whole area, so the absolute values
  // add up to the whole area exactly when no two of them have opposite signs.
  assign any_pos = (!c1_r[CRW-1] && (c1_r != '0)) || (!c2_r[CRW-1] && (c2_r != '0))
                || (!c3_r[CRW-1] && (c3_r != '0));
  assign any_neg = c1_r[CRW-1] || c2_r[CRW-1] || c3_r[CRW-1];

  always_ff @(posedge clk) begin
    hit_r <= !(any_pos && any_neg);
  end

endmodule
`default_nettype wire

>>> src/tlpc_checker.sv
// Port-level checker for the triangle lattice point counter, bound to the top level.
`default_nettype none
module tlpc_checker
  import tlpc_pkg::*;
#(
  parameter int GRID_MAX = 99
) (
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_valid,
  input wire logic   in_stall,
  input wire logic   out_valid,
  input wire logic   out_stall,
  input wire count_t out_tree_count
);

  localparam count_t MAX_COUNT = COUNT_W'(GRID_MAX * GRID_MAX);

  // A result waiting on a stalled output keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tree_count))
    else $error("result changed or vanished while stalled");

  // A count never exceeds the number of grid points.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tree_count <= MAX_COUNT)
    else $error("count above grid size");

  // Once a triangle is taken, the block is busy scanning it.
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken during a scan");

  // A result only appears at the end of a scan.
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall) && !in_stall)
    else $error("result without a finished scan");

endmodule

bind triangle_lattice_point_count_unit tlpc_checker #(.GRID_MAX(GRID_MAX)) u_tlpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_tree_count (out_tree_count)
);
`default_nettype wire

>>> tb/triangle_lattice_point_count_unit_test.sv
// Self-checking testbench for the triangle lattice point counter.
`timescale 1ns / 100ps
module triangle_lattice_point_count_unit_test
  import tlpc_pkg::*;
();

  localparam int GRID_MAX = 99;
  localparam int FRAC_BITS = 8;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int ALL_POINTS = GRID_MAX * GRID_MAX;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int SCAN_CYCLES = ALL_POINTS + 16;
  localparam int STALL_LIMIT = 50000;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } triangle_t;

  typedef struct {
    triangle_t shape;
    bit known;
    count_t tree_count;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic out_valid;
  logic out_stall;
  count_t out_tree_count;

  count_t expected_counts[$];
  directed_row_t directed_rows[$];
  int unsigned fail_count;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned quiet_cycles;

  triangle_lattice_point_count_unit #(
    .GRID_MAX(GRID_MAX),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ax(in_ax),
    .in_ay(in_ay),
    .in_bx(in_bx),
    .in_by(in_by),
    .in_cx(in_cx),
    .in_cy(in_cy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tree_count(out_tree_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint doubled_area(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
    longint cp;
    cp = (qx - px) * (ry - py) - (rx - px) * (qy - py);
    return (cp < 0) ? -cp : cp;
  endfunction

  // A grid point counts when its three sub-areas add up exactly to the whole area.
  function automatic count_t count_lattice_points(triangle_t t);
    longint ax, ay, bx, by, cx, cy;
    longint whole, px, py, sum;
    int points;
    ax = longint'(t.ax);
    ay = longint'(t.ay);
    bx = longint'(t.bx);
    by = longint'(t.by);
    cx = longint'(t.cx);
    cy = longint'(t.cy);
    whole = doubled_area(ax, ay, bx, by, cx, cy);
    points = 0;
    for (int i = 1; i <= GRID_MAX; i++) begin
      px = longint'(i) << FRAC_BITS;
      for (int j = 1; j <= GRID_MAX; j++) begin
        py = longint'(j) << FRAC_BITS;
        sum = doubled_area(px, py, ax, ay, bx, by) + doubled_area(px, py, bx, by, cx, cy)
            + doubled_area(px, py, cx, cy, ax, ay);
        if (sum == whole) begin
          points++;
        end
      end
    end
    return count_t'(points);
  endfunction

  function automatic directed_row_t tri_row(int ax, int ay, int bx, int by, int cx, int cy,
                                            bit known, int tree_count);
    directed_row_t r;
    r.shape = '{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by), coord_t'(cx),
                coord_t'(cy)};
    r.known = known;
    r.tree_count = count_t'(tree_count);
    return r;
  endfunction

  // Mostly arbitrary triangles, with small, collinear and coincident ones mixed in.
  function automatic triangle_t random_triangle();
    triangle_t t;
    int unsigned kind;
    int base_x, base_y, step_x, step_y;
    kind = $urandom_range(99);
    t.ax = coord_t'($urandom_range(COORD_MAX));
    t.ay = coord_t'($urandom_range(COORD_MAX));
    t.bx = coord_t'($urandom_range(COORD_MAX));
    t.by = coord_t'($urandom_range(COORD_MAX));
    t.cx = coord_t'($urandom_range(COORD_MAX));
    t.cy = coord_t'($urandom_range(COORD_MAX));
    if (kind < 25) begin
      base_x = $urandom_range(30000);
      base_y = $urandom_range(30000);
      t.ax = coord_t'(base_x);
      t.ay = coord_t'(base_y);
      t.bx = coord_t'(base_x + $urandom_range(2767));
      t.by = coord_t'(base_y + $urandom_range(2767));
      t.cx = coord_t'(base_x + $urandom_range(2767));
      t.cy = coord_t'(base_y + $urandom_range(2767));
    end else if (kind < 37) begin
      base_x = $urandom_range(28671, 4096);
      base_y = $urandom_range(28671, 4096);
      step_x = int'($urandom_range(4094)) - 2047;
      step_y = int'($urandom_range(4094)) - 2047;
      // Half of the lines are snapped to the grid so that they pass through points.
      if ($urandom_range(1) == 1) begin
        base_x = base_x & ~(ONE - 1);
        base_y = base_y & ~(ONE - 1);
        step_x = step_x & ~(ONE - 1);
        step_y = step_y & ~(ONE - 1);
      end
      t.ax = coord_t'(base_x);
      t.ay = coord_t'(base_y);
      t.bx = coord_t'(base_x + step_x);
      t.by = coord_t'(base_y + step_y);
      t.cx = coord_t'(base_x + 2 * step_x);
      t.cy = coord_t'(base_y + 2 * step_y);
    end else if (kind < 45) begin
      t.bx = t.ax;
      t.by = t.ay;
      if ($urandom_range(1) == 1) begin
        t.cx = t.ax;
        t.cy = t.ay;
      end
    end
    return t;
  endfunction

  // The request is held until it is taken; valid drops only ahead of an idle cycle.
  task automatic send_triangle(triangle_t t, count_t tree_count);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ax <= t.ax;
    in_ay <= t.ay;
    in_bx <= t.bx;
    in_by <= t.by;
    in_cx <= t.cx;
    in_cy <= t.cy;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expected_counts.push_back(tree_count);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic send_random(int unsigned n);
    triangle_t t;
    for (int unsigned k = 0; k < n; k++) begin
      t = random_triangle();
      send_triangle(t, count_lattice_points(t));
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $error("unexpected result: tree_count %0d", out_tree_count);
        fail_count++;
      end else begin
        if (out_tree_count !== expected_counts[0]) begin
          $error("tree_count mismatch: expected %0d, actual %0d", expected_counts[0],
                 out_tree_count);
          fail_count++;
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("triangle_lattice_point_count_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ax = '0;
    in_ay = '0;
    in_bx = '0;
    in_by = '0;
    in_cx = '0;
    in_cy = '0;
    out_stall = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;

    // Coincident vertices: every grid point counts.
    directed_rows.push_back(tri_row(0, 0, 0, 0, 0, 0, 1'b1, ALL_POINTS));
    directed_rows.push_back(tri_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MAX, 1'b1, ALL_POINTS));
    // Collinear vertices: the whole line counts, also beyond the segment.
    directed_rows.push_back(tri_row(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 1'b1, GRID_MAX));
    directed_rows.push_back(tri_row(0, 5 * ONE, ONE, 5 * ONE, COORD_MAX, 5 * ONE, 1'b1,
                                    GRID_MAX));
    directed_rows.push_back(tri_row(99 * ONE, 0, 99 * ONE, 100, 99 * ONE, COORD_MAX, 1'b1,
                                    GRID_MAX));
    directed_rows.push_back(tri_row(0, ONE / 2, ONE / 2, ONE / 2, COORD_MAX, ONE / 2, 1'b1,
                                    0));
    directed_rows.push_back(tri_row(COORD_MAX, 0, COORD_MAX, 100, COORD_MAX, COORD_MAX, 1'b1,
                                    0));
    directed_rows.push_back(tri_row(ONE, ONE, ONE, ONE, 3 * ONE, 2 * ONE, 1'b0, 0));
    // Vertices on grid points count, in both windings.
    directed_rows.push_back(tri_row(ONE, ONE, 2 * ONE, ONE, ONE, 2 * ONE, 1'b1, 3));
    directed_rows.push_back(tri_row(ONE, ONE, ONE, 2 * ONE, 2 * ONE, ONE, 1'b1, 3));
    directed_rows.push_back(tri_row(10, 10, 20, 10, 10, 20, 1'b1, 0));
    directed_rows.push_back(tri_row(0, 0, COORD_MAX, 0, 0, COORD_MAX, 1'b0, 0));
    directed_rows.push_back(tri_row(0, 0, COORD_MAX, 0, COORD_MAX, COORD_MAX, 1'b0, 0));
    directed_rows.push_back(tri_row(COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0, 1'b0,
                                    0));
    directed_rows.push_back(tri_row('h5555, 'h2AAA, 'h2AAA, 'h5555, COORD_MAX, 0, 1'b0, 0));
    directed_rows.push_back(tri_row('h2AAA, 'h5555, 'h5555, 'h2AAA, 0, COORD_MAX, 1'b0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 23;
    out_stall_pct = 79;
    foreach (directed_rows[k]) begin
      send_triangle(directed_rows[k].shape, directed_rows[k].known ?
                    directed_rows[k].tree_count : count_lattice_points(directed_rows[k].shape));
    end
    drain_results();
    send_random(28);

    drain_results();
    in_idle_pct = 79;
    out_stall_pct = 23;
    send_random(28);

    drain_results();
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_random(30);

    drain_results();
    repeat (SCAN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_counts.size() == 0) begin
      $display("triangle_lattice_point_count_unit test passed");
    end else begin
      $display("triangle_lattice_point_count_unit test failed");
    end
    $finish;
  end

endmodule

>>> triangle_lattice_point_count_unit.f
src/tlpc_pkg.sv
src/triangle_lattice_point_count_unit.sv
src/tlpc_checker.sv
tb/triangle_lattice_point_count_unit_test.sv
